// File: hdl/active_inactive_page_replacement_assert.svh
// Assertion macros for the page replacement block
`ifndef ACTIVE_INACTIVE_PAGE_REPLACEMENT_ASSERT_SVH
`define ACTIVE_INACTIVE_PAGE_REPLACEMENT_ASSERT_SVH

// Implication checked on every clock edge outside reset
`define AIPR_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every clock edge, reset included
`define AIPR_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/aipr_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aipr_pkg
// Shared constants and types for the active/inactive page replacement block.
// ---------------------------------------------------------------------------
package aipr_pkg;

  localparam int unsigned ActiveDepthDef   = 64;
  localparam int unsigned InactiveDepthDef = 64;
  localparam int unsigned GhostDepthDef    = 64;
  localparam int unsigned PageBitsDef      = 20;
  localparam int unsigned CountW           = 32;

  typedef enum logic [1:0] {
    WHERE_ACTIVE   = 2'd0,
    WHERE_INACTIVE = 2'd1,
    WHERE_GHOST    = 2'd2,
    WHERE_NEW      = 2'd3
  } where_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_UPDATE = 2'd2
  } state_e;

  // Per-cell control broadcast from the sequencer to every cell of a list
  typedef struct packed {
    logic ins;     // insert a new head this cycle
    logic rem;     // remove matched entry this cycle
  } list_ctrl_t;

endpackage

// File: hdl/aipr_cell.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aipr_cell
// One list slot: holds a page and valid bit, compares against the probe,
// and shifts in from its upstream neighbour or out to its downstream one.
// ---------------------------------------------------------------------------
module aipr_cell import aipr_pkg::*; #(
  parameter int unsigned PageBits = PageBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [PageBits-1:0] probe_i,
  input  list_ctrl_t          ctrl_i,
  // shifted towards tail: take upstream when at or after the insert point
  input  logic                take_up_i,
  // shifted towards head: take downstream when at or after the removed slot
  input  logic                take_dn_i,
  input  logic [PageBits-1:0] up_page_i,
  input  logic                up_valid_i,
  input  logic [PageBits-1:0] dn_page_i,
  input  logic                dn_valid_i,
  output logic [PageBits-1:0] page_o,
  output logic                valid_o,
  output logic                match_o
);

  logic [PageBits-1:0] page_q, page_d;
  logic                valid_q, valid_d;

  assign match_o = valid_q && (page_q == probe_i);
  assign page_o  = page_q;
  assign valid_o = valid_q;

  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    if (ctrl_i.rem && take_dn_i) begin
      page_d  = dn_page_i;
      valid_d = dn_valid_i;
    end else if (ctrl_i.ins && take_up_i) begin
      page_d  = up_page_i;
      valid_d = up_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

endmodule

// File: hdl/aipr_list.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aipr_list
// A chain of cells forming one recency list, head at slot 0.
// ---------------------------------------------------------------------------
module aipr_list import aipr_pkg::*; #(
  parameter int unsigned Depth    = ActiveDepthDef,
  parameter int unsigned PageBits = PageBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [PageBits-1:0] probe_i,
  input  list_ctrl_t          ctrl_i,
  input  logic [PageBits-1:0] head_page_i,
  output logic                hit_o,
  output logic                full_o,
  output logic [PageBits-1:0] tail_page_o
);

  logic [Depth-1:0]               match;
  logic [Depth-1:0]               vld;
  logic [Depth-1:0][PageBits-1:0] pg;
  logic [Depth-1:0]               at_or_after;  // prefix-OR of match

  assign hit_o       = |match;
  assign full_o      = vld[Depth-1];
  assign tail_page_o = pg[Depth-1];

  // Removed slot and every slot after it pull from downstream
  always_comb begin
    at_or_after[0] = match[0];
    for (int i = 1; i < Depth; i++) begin
      at_or_after[i] = at_or_after[i-1] | match[i];
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic [PageBits-1:0] up_pg, dn_pg;
    logic                up_v, dn_v;
    if (i == 0) begin : g_head
      assign up_pg = head_page_i;
      assign up_v  = 1'b1;
    end else begin : g_mid
      assign up_pg = pg[i-1];
      assign up_v  = vld[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign dn_pg = pg[i];
      assign dn_v  = 1'b0;
    end else begin : g_body
      assign dn_pg = pg[i+1];
      assign dn_v  = vld[i+1];
    end
    aipr_cell #(.PageBits(PageBits)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .probe_i    (probe_i),
      .ctrl_i     (ctrl_i),
      .take_up_i  (1'b1),
      .take_dn_i  (at_or_after[i]),
      .up_page_i  (up_pg),
      .up_valid_i (up_v),
      .dn_page_i  (dn_pg),
      .dn_valid_i (dn_v),
      .page_o     (pg[i]),
      .valid_o    (vld[i]),
      .match_o    (match[i])
    );
  end

endmodule

// File: hdl/active_inactive_page_replacement.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// active_inactive_page_replacement
// Two-list LRU with a ghost list, built as three chains of compare/shift cells.
// ---------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o) carries one page number per
//    transaction; output channel (out_valid_o/out_ready_i) carries hit/miss,
//    where the page was found, and saturating hit and miss totals.
//  - Each transaction passes accept, a remove step (matching cell and its
//    successors shift towards the head) and an insert step (head insert
//    with tail cascade active -> inactive -> ghost); the result is registered
//    when the insert step commits.
//  - One transaction is in flight at a time; a new page is taken only once
//    the previous one has passed the remove-then-insert sequence on the
//    single shift path of each chain and its result has been registered.
//  - The result sits in an output register; the block accepts the next page
//    while that result still waits, and holds in the insert cycle (inserting
//    once, on leaving it) when a second result would have nowhere to go.
//  - Reset clears every valid bit and both counters; page storage is not
//    reset. No clearing pass is needed.
// ---------------------------------------------------------------------------
module active_inactive_page_replacement import aipr_pkg::*; #(
  parameter int unsigned ACTIVE_DEPTH   = ActiveDepthDef,
  parameter int unsigned INACTIVE_DEPTH = InactiveDepthDef,
  parameter int unsigned GHOST_DEPTH    = GhostDepthDef,
  parameter int unsigned PAGE_BITS      = PageBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [PAGE_BITS-1:0] page_number_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 was_hit_o,
  output logic [1:0]           found_where_o,
  output logic [CountW-1:0]    total_hits_o,
  output logic [CountW-1:0]    total_misses_o
);

  state_e state_q, state_d;
  logic [PAGE_BITS-1:0] page_q;
  where_e where_q, where_d;

  logic a_hit, i_hit, g_hit, a_full, i_full, g_full;
  logic [PAGE_BITS-1:0] a_tail, i_tail, g_tail;
  list_ctrl_t a_ctrl, i_ctrl, g_ctrl;

  logic out_valid_q;
  logic was_hit_q;
  where_e out_where_q;
  logic [CountW-1:0] hits_q, misses_q;

  logic out_free;
  logic commit;

  // Insert destination: every hit and every ghost hit goes to active
  logic to_active;
  assign to_active = (where_q != WHERE_NEW);

  // Remove cycle: only the matched list shifts. Insert cycle: head push with
  // cascade. The inactive list has room on promotion since its entry left.
  always_comb begin
    a_ctrl = '0;
    i_ctrl = '0;
    g_ctrl = '0;
    if (state_q == ST_SEARCH) begin
      a_ctrl.rem = (where_d == WHERE_ACTIVE);
      i_ctrl.rem = (where_d == WHERE_INACTIVE);
      g_ctrl.rem = (where_d == WHERE_GHOST);
    end else if (commit) begin
      a_ctrl.ins = to_active;
      i_ctrl.ins = to_active ? a_full : 1'b1;
      g_ctrl.ins = to_active ? (a_full && i_full) : i_full;
    end
  end

  always_comb begin
    if (a_hit) begin
      where_d = WHERE_ACTIVE;
    end else if (i_hit) begin
      where_d = WHERE_INACTIVE;
    end else if (g_hit) begin
      where_d = WHERE_GHOST;
    end else begin
      where_d = WHERE_NEW;
    end
  end

  aipr_list #(.Depth(ACTIVE_DEPTH), .PageBits(PAGE_BITS)) u_active (
    .clk_i(clk_i), .rst_ni(rst_ni), .probe_i(page_q), .ctrl_i(a_ctrl),
    .head_page_i(page_q), .hit_o(a_hit), .full_o(a_full), .tail_page_o(a_tail)
  );

  aipr_list #(.Depth(INACTIVE_DEPTH), .PageBits(PAGE_BITS)) u_inactive (
    .clk_i(clk_i), .rst_ni(rst_ni), .probe_i(page_q), .ctrl_i(i_ctrl),
    .head_page_i(to_active ? a_tail : page_q),
    .hit_o(i_hit), .full_o(i_full), .tail_page_o(i_tail)
  );

  // Ghost tail falls off the end of the chain
  aipr_list #(.Depth(GHOST_DEPTH), .PageBits(PAGE_BITS)) u_ghost (
    .clk_i(clk_i), .rst_ni(rst_ni), .probe_i(page_q), .ctrl_i(g_ctrl),
    .head_page_i(i_tail), .hit_o(g_hit), .full_o(g_full), .tail_page_o(g_tail)
  );

  logic unused_ghost;
  assign unused_ghost = g_full ^ (^g_tail);

  // Result may only be written into an empty or draining output register
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_valid_i) state_d = ST_SEARCH;
      ST_SEARCH: state_d = ST_UPDATE;
      ST_UPDATE: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  assign commit = (state_q == ST_UPDATE) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      hits_q      <= '0;
      misses_q    <= '0;
    end else begin
      // Hold in UPDATE without inserting again: insert only on the commit cycle
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
        if (where_q == WHERE_ACTIVE || where_q == WHERE_INACTIVE) begin
          if (hits_q != '1) hits_q <= hits_q + 1'b1;
        end else begin
          if (misses_q != '1) misses_q <= misses_q + 1'b1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) page_q <= page_number_i;
    if (state_q == ST_SEARCH) where_q <= where_d;
    if (commit) begin
      was_hit_q   <= (where_q == WHERE_ACTIVE || where_q == WHERE_INACTIVE);
      out_where_q <= where_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign was_hit_o      = was_hit_q;
  assign found_where_o  = out_where_q;
  assign total_hits_o   = hits_q;
  assign total_misses_o = misses_q;

endmodule

// File: hdl/aipr_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aipr_checker
// Port-level checks for the page replacement block.
// ---------------------------------------------------------------------------
`include "active_inactive_page_replacement_assert.svh"
module aipr_checker import aipr_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              was_hit_o,
  input logic [1:0]        found_where_o,
  input logic [CountW-1:0] total_hits_o,
  input logic [CountW-1:0] total_misses_o
);

  `AIPR_ASSERT(a_hit_code, clk_i, rst_ni, out_valid_o |-> (was_hit_o == !found_where_o[1]), "hit flag disagrees with location")
  `AIPR_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(total_hits_o) && $stable(total_misses_o)), "stalled result changed")
  `AIPR_ASSERT(a_no_back, clk_i, rst_ni, (in_valid_i && in_ready_o) |=> !in_ready_o, "took two pages back to back")
  `AIPR_ASSERT(a_hits_mono, clk_i, rst_ni, ##1 (total_hits_o >= $past(total_hits_o)), "hit count went down")
  `AIPR_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !out_valid_o, "result offered in reset")

endmodule

bind active_inactive_page_replacement aipr_checker u_aipr_checker (.*);

// File: test/active_inactive_page_replacement_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// active_inactive_page_replacement_tb
// Drives page accesses into the two-list LRU block and checks every result
// against a behavioural copy of the active, inactive and ghost lists.
// ---------------------------------------------------------------------------

// Scoreboard: keeps its own copy of the three lists and the totals, and
// queues the result that each accepted page should produce.
class page_lru_board;
  typedef struct {
    logic                  hit;
    aipr_pkg::where_e      where;
    logic [31:0]           hits;
    logic [31:0]           misses;
  } access_res_t;

  logic [19:0] act_q[$];
  logic [19:0] inact_q[$];
  logic [19:0] ghost_q[$];
  logic [31:0] hit_cnt;
  logic [31:0] miss_cnt;
  access_res_t pending_q[$];
  int          errors;

  function new();
    hit_cnt  = '0;
    miss_cnt = '0;
    errors   = 0;
  endfunction

  // Head insert with tail cascade active -> inactive -> ghost -> dropped
  function void push_inact(logic [19:0] p);
    inact_q.insert(0, p);
    if (inact_q.size() > 64) begin
      ghost_q.insert(0, inact_q[$]);
      inact_q.delete(inact_q.size() - 1);
      if (ghost_q.size() > 64) ghost_q.delete(ghost_q.size() - 1);
    end
  endfunction

  function void push_act(logic [19:0] p);
    logic [19:0] spill;
    act_q.insert(0, p);
    if (act_q.size() > 64) begin
      spill = act_q[$];
      act_q.delete(act_q.size() - 1);
      push_inact(spill);
    end
  endfunction

  function int find_idx(ref logic [19:0] q[$], input logic [19:0] p);
    foreach (q[i]) if (q[i] == p) return i;
    return -1;
  endfunction

  function void note_access(logic [19:0] p);
    access_res_t r;
    int i;
    i = find_idx(act_q, p);
    if (i >= 0) begin
      act_q.delete(i); push_act(p); r.hit = 1; r.where = aipr_pkg::WHERE_ACTIVE;
    end else begin
      i = find_idx(inact_q, p);
      if (i >= 0) begin
        inact_q.delete(i); push_act(p); r.hit = 1; r.where = aipr_pkg::WHERE_INACTIVE;
      end else begin
        i = find_idx(ghost_q, p);
        r.hit = 0;
        if (i >= 0) begin
          ghost_q.delete(i); push_act(p); r.where = aipr_pkg::WHERE_GHOST;
        end else begin
          push_inact(p); r.where = aipr_pkg::WHERE_NEW;
        end
      end
    end
    if (r.hit) begin
      if (hit_cnt != '1) hit_cnt++;
    end else if (miss_cnt != '1) miss_cnt++;
    r.hits   = hit_cnt;
    r.misses = miss_cnt;
    pending_q.push_back(r);
  endfunction

  function void check_result(logic hit, logic [1:0] where, logic [31:0] hits,
                             logic [31:0] misses);
    access_res_t e;
    if (pending_q.size() == 0) begin
      $error("unexpected result: hit=%0d where=%0d", hit, where);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (hit !== e.hit) begin
      $error("was_hit: expected %0d, got %0d", e.hit, hit); errors++;
    end
    if (where !== e.where) begin
      $error("found_where: expected %0d, got %0d", e.where, where); errors++;
    end
    if (hits !== e.hits) begin
      $error("total_hits: expected %0d, got %0d", e.hits, hits); errors++;
    end
    if (misses !== e.misses) begin
      $error("total_misses: expected %0d, got %0d", e.misses, misses); errors++;
    end
  endfunction
endclass

module active_inactive_page_replacement_tb;
  import aipr_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [19:0] page_number_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic        was_hit_o;
  logic [1:0]  found_where_o;
  logic [31:0] total_hits_o;
  logic [31:0] total_misses_o;

  page_lru_board board = new();

  // Idle percentages per phase; stall_hold forces a long receiver hold-off
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          stall_hold;

  active_inactive_page_replacement DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .page_number_i,
    .out_valid_o, .out_ready_i, .was_hit_o, .found_where_o,
    .total_hits_o, .total_misses_o
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Reset held low from the start, then released once
  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Hard limit, far beyond the slowest correct run
  initial begin
    #4000000;
    $display("== FAIL ==");
    $finish;
  end

  // Result side: sample on the edge, note the transaction, then pick the
  // next ready value. Only one assignment to out_ready_i per edge.
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i)
        board.check_result(was_hit_o, found_where_o, total_hits_o, total_misses_o);
      out_ready_i <= !stall_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // One page transaction: optional idle gap, then hold valid until taken
  task automatic send_page(logic [19:0] p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    page_number_i <= p;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_access(p);
  endtask

  // Random page mostly from a small working set so that every list and the
  // ghost path are exercised; otherwise a fully random number.
  function automatic logic [19:0] pick_page(int unsigned span);
    int unsigned k;
    k = $urandom_range(99);
    if (k < 85) return 20'(($urandom_range(span - 1) * 20'h0_4C1D) ^ 20'hA_5A5A);
    return 20'($urandom);
  endfunction

  task automatic run_phase(int unsigned n, int unsigned s_pct, int unsigned r_pct);
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    repeat (n) send_page(pick_page($urandom_range(1, 4) * 60));
  endtask

  initial begin
    int unsigned i;
    int unsigned wait_cnt;
    in_valid_i     = 1'b0;
    page_number_i  = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    stall_hold     = 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);

    // Directed: field extremes, each outcome class, an active hit, an
    // inactive promotion, eviction into the ghost list and a ghost re-entry
    send_page(20'h00000);
    send_page(20'hFFFFF);
    send_page(20'hFFFFF);          // inactive hit, promoted
    send_page(20'hFFFFF);          // active hit
    send_page(20'h55555);
    send_page(20'hAAAAA);
    send_page(20'h00000);

    // Fill inactive far past its depth so early pages fall into the ghost list
    for (i = 0; i < 140; i++) send_page(20'h10000 + 20'(i));
    send_page(20'h10000);          // already dropped off the ghost list: a miss, enters inactive
    // Re-access pages 70 to 139 (ghost hits, then inactive promotions) so active overflows back into inactive
    for (i = 70; i < 140; i++) send_page(20'h10000 + 20'(i));
    send_page(20'h10046);          // was in active, spilled back into inactive, so a hit there
    // Long receiver hold-off while the sender keeps offering pages
    stall_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        stall_hold = 1'b0;
      end
      repeat (20) send_page(pick_page(120));
    join

    run_phase(450, 0, 0);
    run_phase(350, 74, 0);
    run_phase(350, 0, 74);
    run_phase(350, 6, 6);
    in_valid_i <= 1'b0;

    wait_cnt = 0;
    while (board.pending_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (20) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
